/* rtl/core/fegf_pkg.sv */
// Package for the four-electrode geometric factor pipeline.
// Holds status codes, mode codes, config indexes and shared stage types.
// No dependencies.
package fegf_pkg;

	localparam int CoordW = 24;
	localparam int DiffW = 25;
	localparam int D2W = 51;
	localparam int RadW = 64;
	localparam int RootW = 32;
	localparam int TermW = 41;
	localparam int SumW = 51;
	localparam int QuotW = 56;
	localparam int FactW = 48;
	localparam logic [QuotW-1:0] Pi2Q48 = 56'h06487ED5110B46;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OFF_GRID  = 2'd1,
		ST_DEGEN     = 2'd2,
		ST_SATURATED = 2'd3
	} status_t;

	typedef enum logic {
		MODE_LOAD    = 1'b0,
		MODE_COMPUTE = 1'b1
	} mode_t;

	typedef enum logic [1:0] {
		CFG_X_LOW  = 2'd0,
		CFG_X_HIGH = 2'd1,
		CFG_Z_LOW  = 2'd2,
		CFG_Z_HIGH = 2'd3
	} cfg_idx_t;

	// Per-item control carried alongside the arithmetic.
	typedef struct packed {
		logic    vld;
		logic    compute;
		logic    degen;
		status_t status;
	} ctl_t;

endpackage

/* rtl/core/four_electrode_geometric_factor.sv */
// done follows the table read, the difference, square and sum registers, the root stages,
// the coincident check, the reciprocal dividers, sum, magnitude, quotient divider and output.
// Throughput: one transaction per cycle; busy stays low, every stage advances each cycle.
// Loads inside the grid write the position table at the first stage; a later compute sees them.
// The receiver cannot stall: done pulses for one cycle per transaction.
// Reset (arst_n low) clears valid bits, sets grid to full span; table undefined until loaded.
module four_electrode_geometric_factor import fegf_pkg::*; #(
	parameter int ELECTRODES = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic                 mode,
	input  logic [7:0]           electrode_slot,
	input  logic signed [23:0]   pos_x,
	input  logic signed [23:0]   pos_z,
	input  logic [8:0]           current_a,
	input  logic [8:0]           current_b,
	input  logic [8:0]           potential_m,
	input  logic [8:0]           potential_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic [23:0]          cfg_data,
	output logic                 done,
	output logic signed [47:0]   factor,
	output logic [1:0]           status
);

	localparam int AW = (ELECTRODES > 1) ? $clog2(ELECTRODES) : 1;

	logic signed [CoordW-1:0] gxl_q, gxh_q, gzl_q, gzh_q;
	// A/B and M/N read from separate copies, two reads each per cycle
	logic signed [CoordW-1:0] xtab_q [ELECTRODES];
	logic signed [CoordW-1:0] ztab_q [ELECTRODES];
	logic signed [CoordW-1:0] xtab_mn_q [ELECTRODES];
	logic signed [CoordW-1:0] ztab_mn_q [ELECTRODES];

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gxl_q <= -24'sd8388608;
			gxh_q <= 24'sd8388607;
			gzl_q <= -24'sd8388608;
			gzh_q <= 24'sd8388607;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_X_LOW:  gxl_q <= cfg_data;
				CFG_X_HIGH: gxh_q <= cfg_data;
				CFG_Z_LOW:  gzl_q <= cfg_data;
				CFG_Z_HIGH: gzh_q <= cfg_data;
				default: ;
			endcase
		end
	end

	function automatic logic in_box(logic signed [CoordW-1:0] v, logic signed [CoordW-1:0] lo,
		logic signed [CoordW-1:0] hi);
		logic signed [CoordW-1:0] mn, mx;
		mn = (lo < hi) ? lo : hi;
		mx = (lo < hi) ? hi : lo;
		return (v >= mn) && (v <= mx);
	endfunction

	// Stage 0: accept, check grid, write table, decode indexes.
	logic acc;
	logic in_grid, slot_ok;
	logic [8:0] idx [4];
	logic [3:0] pres;
	assign acc = start && !busy;
	assign in_grid = in_box(pos_x, gxl_q, gxh_q) && in_box(pos_z, gzl_q, gzh_q);
	assign slot_ok = (int'(electrode_slot) < ELECTRODES);
	always_comb begin
		idx[0] = current_a;
		idx[1] = current_b;
		idx[2] = potential_m;
		idx[3] = potential_n;
		for (int i = 0; i < 4; i++) begin
			pres[i] = (idx[i] != 9'd0) && (int'(idx[i]) <= ELECTRODES);
		end
	end

	always_ff @(posedge clk) begin
		if (acc && mode == MODE_LOAD && in_grid && slot_ok) begin
			xtab_q[AW'(electrode_slot)] <= pos_x;
			ztab_q[AW'(electrode_slot)] <= pos_z;
			xtab_mn_q[AW'(electrode_slot)] <= pos_x;
			ztab_mn_q[AW'(electrode_slot)] <= pos_z;
		end
	end

	ctl_t ctl_s1;
	logic [3:0] pres_s1;
	logic signed [CoordW-1:0] ex_s1 [4];
	logic signed [CoordW-1:0] ez_s1 [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= '{vld: acc, compute: (mode == MODE_COMPUTE), degen: 1'b0,
				status: status_t'((mode == MODE_LOAD && !in_grid) ? ST_OFF_GRID : ST_OK)};
		end
	end

	always_ff @(posedge clk) begin
		pres_s1 <= pres;
		for (int i = 0; i < 2; i++) begin
			ex_s1[i] <= xtab_q[AW'(idx[i] - 9'd1)];
			ez_s1[i] <= ztab_q[AW'(idx[i] - 9'd1)];
			ex_s1[i+2] <= xtab_mn_q[AW'(idx[i+2] - 9'd1)];
			ez_s1[i+2] <= ztab_mn_q[AW'(idx[i+2] - 9'd1)];
		end
	end

	// Pairs: AM, AN, BM, BN
	localparam int PA [4] = '{0, 0, 1, 1};
	localparam int PB [4] = '{2, 3, 2, 3};

	// Stage 2: differences. Stage 3: squares. Stage 4: sum.
	ctl_t ctl_s2, ctl_s3, ctl_s4;
	logic [3:0] use_s2, use_s3, use_s4;
	logic signed [DiffW-1:0] dx_s2 [4], dz_s2 [4];
	logic [D2W-2:0] sx_s3 [4], sz_s3 [4];
	logic [3:0][RadW-1:0] rad_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
		end else begin
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
		end
	end

	always_ff @(posedge clk) begin
		for (int p = 0; p < 4; p++) begin
			use_s2[p] <= pres_s1[PA[p]] && pres_s1[PB[p]];
			dx_s2[p] <= DiffW'(ex_s1[PA[p]]) - DiffW'(ex_s1[PB[p]]);
			dz_s2[p] <= DiffW'(ez_s1[PA[p]]) - DiffW'(ez_s1[PB[p]]);
			sx_s3[p] <= (D2W-1)'(unsigned'(50'(dx_s2[p] * dx_s2[p])));
			sz_s3[p] <= (D2W-1)'(unsigned'(50'(dz_s2[p] * dz_s2[p])));
			rad_s4[p] <= {1'b0, D2W'({1'b0, sx_s3[p]} + {1'b0, sz_s3[p]}), 12'b0};
		end
		use_s3 <= use_s2;
		use_s4 <= use_s3;
	end

	ctl_t ctl_sq;
	logic [3:0][RootW-1:0] root_sq;
	logic [3:0] use_sq;

	fegf_isqrt #(.LANES(4)) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl_in   (ctl_s4),
		.rad_in   (rad_s4),
		.use_in   (use_s4),
		.ctl_out  (ctl_sq),
		.root_out (root_sq),
		.use_out  (use_sq)
	);

	// Coincident check registered before reciprocal dividers.
	ctl_t ctl_s5;
	ctl_t ctl_sq_n;
	logic [3:0][RootW-1:0] root_s5;
	logic [3:0] use_s5;
	always_comb begin
		ctl_sq_n = ctl_sq;
		for (int p = 0; p < 4; p++) begin
			if (use_sq[p] && root_sq[p] == '0) begin
				ctl_sq_n.degen = 1'b1;
			end
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s5 <= '0;
		end else begin
			ctl_s5 <= ctl_sq_n;
		end
	end
	always_ff @(posedge clk) begin
		for (int p = 0; p < 4; p++) begin
			root_s5[p] <= (use_sq[p] && root_sq[p] != '0) ? root_sq[p] : '0;
			use_s5[p] <= use_sq[p] && root_sq[p] != '0;
		end
	end

	// Reciprocal: 2^54 / r. r >= 64 when nonzero, so quotient fits 49 bits; take 55-bit path.
	ctl_t ctl_rc [4];
	logic [54:0] quo_rc [4];
	logic [0:0] side_rc [4];
	for (genvar p = 0; p < 4; p++) begin : g_rc
		fegf_div #(.NW(55), .DW(RootW), .SW(1)) u_rdiv (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl_in   (ctl_s5),
			.num_in   (use_s5[p] ? {1'b1, 54'b0} : 55'b0),
			.den_in   (use_s5[p] ? root_s5[p] : 32'd1),
			.side_in  (use_s5[p]),
			.ctl_out  (ctl_rc[p]),
			.quo_out  (quo_rc[p]),
			.side_out (side_rc[p])
		);
	end

	// Sum stage and magnitude.
	ctl_t ctl_s6, ctl_s7;
	ctl_t ctl_s6_n;
	logic signed [SumW-1:0] s_s6;
	logic [SumW-1:0] mag_s7;
	logic neg_s7;

	always_comb begin
		ctl_s6_n = ctl_s6;
		if (s_s6 == '0) begin
			ctl_s6_n.degen = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s6 <= '0;
			ctl_s7 <= '0;
		end else begin
			ctl_s6 <= ctl_rc[0];
			ctl_s7 <= ctl_s6_n;
		end
	end

	always_ff @(posedge clk) begin
		s_s6 <= SumW'(quo_rc[0]) - SumW'(quo_rc[1]) - SumW'(quo_rc[2]) + SumW'(quo_rc[3]);
		neg_s7 <= s_s6[SumW-1];
		mag_s7 <= s_s6[SumW-1] ? SumW'(-s_s6) : SumW'(s_s6);
	end

	ctl_t ctl_dv;
	logic [QuotW-1:0] q_dv;
	logic [0:0] neg_dv;

	fegf_div #(.NW(QuotW), .DW(SumW), .SW(1)) u_qdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl_in   (ctl_s7),
		.num_in   (Pi2Q48 + QuotW'(mag_s7 >> 1)),
		.den_in   ((mag_s7 == '0) ? SumW'(1) : mag_s7),
		.side_in  (neg_s7),
		.ctl_out  (ctl_dv),
		.quo_out  (q_dv),
		.side_out (neg_dv)
	);

	// Output stage: saturate and select.
	localparam logic [QuotW-1:0] QMaxPos = QuotW'(48'h7FFFFFFFFFFF);
	localparam logic [QuotW-1:0] QMaxNeg = QuotW'(49'h0800000000000);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= ctl_dv.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (!ctl_dv.compute) begin
			factor <= '0;
			status <= ctl_dv.status;
		end else if (ctl_dv.degen) begin
			factor <= '0;
			status <= ST_DEGEN;
		end else if (!neg_dv[0]) begin
			factor <= (q_dv > QMaxPos) ? FactW'(QMaxPos) : FactW'(q_dv);
			status <= (q_dv > QMaxPos) ? ST_SATURATED : ST_OK;
		end else begin
			factor <= (q_dv > QMaxNeg) ? FactW'(-QMaxNeg) : FactW'(-q_dv);
			status <= (q_dv > QMaxNeg) ? ST_SATURATED : ST_OK;
		end
	end

endmodule

/* rtl/core/fegf_isqrt.sv */
// Pipelined integer square root, one result bit per stage.
// Carries a control struct in lockstep. Uses fegf_pkg.
module fegf_isqrt import fegf_pkg::*; #(
	parameter int LANES = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ctl_t                        ctl_in,
	input  logic [LANES-1:0][RadW-1:0]  rad_in,
	input  logic [LANES-1:0]            use_in,
	output ctl_t                        ctl_out,
	output logic [LANES-1:0][RootW-1:0] root_out,
	output logic [LANES-1:0]            use_out
);

	ctl_t                        ctl_s1 [RootW+1];
	logic [LANES-1:0][RadW-1:0]  rem_s1 [RootW+1];
	logic [LANES-1:0][RootW-1:0] res_s1 [RootW+1];
	logic [LANES-1:0]            use_s1 [RootW+1];

	always_comb begin
		ctl_s1[0] = ctl_in;
		rem_s1[0] = rad_in;
		res_s1[0] = '0;
		use_s1[0] = use_in;
	end

	for (genvar k = 0; k < RootW; k++) begin : g_bit
		logic [LANES-1:0][RadW-1:0]  rem_n;
		logic [LANES-1:0][RootW-1:0] res_n;
		always_comb begin
			for (int l = 0; l < LANES; l++) begin
				logic [RadW+1:0] trial;
				logic [RadW+1:0] cand;
				cand = {2'b0, rem_s1[k][l]};
				trial = ({2'b0, 32'b0, res_s1[k][l]} << (RootW - k))
					| ({{(RadW+1){1'b0}}, 1'b1} << (2 * (RootW - 1 - k)));
				res_n[l] = res_s1[k][l];
				rem_n[l] = rem_s1[k][l];
				if (cand >= trial) begin
					rem_n[l] = RadW'(cand - trial);
					res_n[l][RootW-1-k] = 1'b1;
				end
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s1[k+1] <= '0;
			end else begin
				ctl_s1[k+1] <= ctl_s1[k];
			end
		end
		always_ff @(posedge clk) begin
			rem_s1[k+1] <= rem_n;
			res_s1[k+1] <= res_n;
			use_s1[k+1] <= use_s1[k];
		end
	end

	assign ctl_out = ctl_s1[RootW];
	assign root_out = res_s1[RootW];
	assign use_out = use_s1[RootW];

endmodule

/* rtl/core/fegf_div.sv */
// Pipelined restoring divider, unsigned, one quotient bit per stage.
// Carries a control struct and a side word in lockstep. Uses fegf_pkg.
module fegf_div import fegf_pkg::*; #(
	parameter int NW = 56,
	parameter int DW = 43,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  ctl_t          ctl_in,
	input  logic [NW-1:0] num_in,
	input  logic [DW-1:0] den_in,
	input  logic [SW-1:0] side_in,
	output ctl_t          ctl_out,
	output logic [NW-1:0] quo_out,
	output logic [SW-1:0] side_out
);

	ctl_t          ctl_s1  [NW+1];
	logic [NW-1:0] num_s1  [NW+1];
	logic [DW:0]   rem_s1  [NW+1];
	logic [DW-1:0] den_s1  [NW+1];
	logic [SW-1:0] side_s1 [NW+1];

	always_comb begin
		ctl_s1[0] = ctl_in;
		num_s1[0] = num_in;
		rem_s1[0] = '0;
		den_s1[0] = den_in;
		side_s1[0] = side_in;
	end

	for (genvar k = 0; k < NW; k++) begin : g_bit
		logic [DW+1:0] sh;
		logic [DW:0]   rem_n;
		logic [NW-1:0] num_n;
		always_comb begin
			sh = {rem_s1[k], num_s1[k][NW-1]};
			num_n = {num_s1[k][NW-2:0], 1'b0};
			if (sh >= {2'b0, den_s1[k]}) begin
				rem_n = (DW+1)'(sh - {2'b0, den_s1[k]});
				num_n[0] = 1'b1;
			end else begin
				rem_n = sh[DW:0];
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s1[k+1] <= '0;
			end else begin
				ctl_s1[k+1] <= ctl_s1[k];
			end
		end
		always_ff @(posedge clk) begin
			num_s1[k+1] <= num_n;
			rem_s1[k+1] <= rem_n;
			den_s1[k+1] <= den_s1[k];
			side_s1[k+1] <= side_s1[k];
		end
	end

	assign ctl_out = ctl_s1[NW];
	assign quo_out = num_s1[NW];
	assign side_out = side_s1[NW];

endmodule

/* rtl/core/fegf_checker.sv */
// Port-level checker for four_electrode_geometric_factor, with its bind.
// Uses fegf_pkg for status codes.
module fegf_checker import fegf_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        busy,
	input logic        done,
	input logic [47:0] factor,
	input logic [1:0]  status
);

	a_no_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_DEGEN |-> factor == '0)
		else $error("degenerate result not zero");
	a_grid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_OFF_GRID |-> factor == '0)
		else $error("off-grid result not zero");
	a_idle_reset: assert property (@(posedge clk) $rose(arst_n) |-> !done)
		else $error("done right after reset");

endmodule

bind four_electrode_geometric_factor fegf_checker u_fegf_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.busy   (busy),
	.done   (done),
	.factor (factor),
	.status (status)
);

/* tb/sv/tb_four_electrode_geometric_factor.sv */
`timescale 1ns / 100ps
// Testbench for four_electrode_geometric_factor: random and directed load/compute traffic,
// with a bit-exact predictor of the geometric factor checked against every result strobe.
// Depends on fegf_pkg and the four_electrode_geometric_factor RTL.
module tb_four_electrode_geometric_factor;
	import fegf_pkg::*;

	localparam int NumSlots = 256;
	localparam int LatencyCycles = 150;
	localparam longint CycleLimit = 600000;

	typedef struct {
		mode_t                mode;
		logic [7:0]           slot;
		logic signed [23:0]   px;
		logic signed [23:0]   pz;
		logic [8:0]           ia, ib, im, in_n;
	} electrode_txn_t;

	typedef struct {
		logic [47:0] factor;
		status_t     status;
	} factor_result_t;

	class geom_factor_tracker;
		logic signed [23:0] tab_x [NumSlots];
		logic signed [23:0] tab_z [NumSlots];
		bit                 loaded [NumSlots];
		logic signed [23:0] bounds [4];
		factor_result_t     pending_factors [$];
		int                 fails;

		function new();
			bounds[CFG_X_LOW] = -24'sd8388608;
			bounds[CFG_X_HIGH] = 24'sd8388607;
			bounds[CFG_Z_LOW] = -24'sd8388608;
			bounds[CFG_Z_HIGH] = 24'sd8388607;
			fails = 0;
		endfunction

		function void write_bound(cfg_idx_t idx, logic [23:0] val);
			bounds[idx] = val;
		endfunction

		function bit within_box(logic signed [23:0] v, logic signed [23:0] lo,
				logic signed [23:0] hi);
			if (lo < hi)
				return v >= lo && v <= hi;
			return v >= hi && v <= lo;
		endfunction

		function longint unsigned int_root(longint unsigned v);
			longint unsigned r, c;
			r = 0;
			for (int b = 31; b >= 0; b--) begin
				c = r | (64'd1 << b);
				if (c * c <= v)
					r = c;
			end
			return r;
		endfunction

		// reciprocal distance in Q.48, zero when either side is absent or the two coincide
		function longint pair_term(int unsigned p, int unsigned q, ref bit touching);
			longint dx, dz;
			longint unsigned d2;
			if (p == 0 || q == 0 || p > NumSlots || q > NumSlots)
				return 0;
			dx = longint'(tab_x[p-1]) - longint'(tab_x[q-1]);
			dz = longint'(tab_z[p-1]) - longint'(tab_z[q-1]);
			d2 = dx * dx + dz * dz;
			if (d2 == 0) begin
				touching = 1;
				return 0;
			end
			return longint'((64'd1 << 54) / int_root(d2 << 12));
		endfunction

		function void log_transaction(electrode_txn_t t);
			factor_result_t e;
			longint s;
			longint unsigned mag, q;
			bit touching;
			e.factor = '0;
			e.status = ST_OK;
			if (t.mode == MODE_LOAD) begin
				if (!(within_box(t.px, bounds[CFG_X_LOW], bounds[CFG_X_HIGH]) &&
						within_box(t.pz, bounds[CFG_Z_LOW], bounds[CFG_Z_HIGH])))
					e.status = ST_OFF_GRID;
				else begin
					tab_x[t.slot] = t.px;
					tab_z[t.slot] = t.pz;
					loaded[t.slot] = 1;
				end
			end else begin
				touching = 0;
				s = pair_term(t.ia, t.im, touching) - pair_term(t.ia, t.in_n, touching)
					- pair_term(t.ib, t.im, touching) + pair_term(t.ib, t.in_n, touching);
				if (touching || s == 0)
					e.status = ST_DEGEN;
				else begin
					mag = s < 0 ? longint'(-s) : longint'(s);
					q = (64'(Pi2Q48) + mag / 2) / mag;
					if (s > 0) begin
						if (q > 64'h7FFFFFFFFFFF) begin
							q = 64'h7FFFFFFFFFFF;
							e.status = ST_SATURATED;
						end
						e.factor = q[47:0];
					end else begin
						if (q > 64'h800000000000) begin
							q = 64'h800000000000;
							e.status = ST_SATURATED;
						end
						e.factor = 48'(-q);
					end
				end
			end
			pending_factors.push_back(e);
		endfunction

		function void compare_result(logic [47:0] f, logic [1:0] st);
			factor_result_t e;
			if (pending_factors.size() == 0) begin
				$error("unexpected result: factor %h status %0d", f, st);
				fails++;
				return;
			end
			e = pending_factors.pop_front();
			if (f !== e.factor) begin
				$error("factor: expected %h, actual %h", e.factor, f);
				fails++;
			end
			if (st !== e.status) begin
				$error("status: expected %0d, actual %0d", e.status, st);
				fails++;
			end
		endfunction
	endclass

	logic               clk, arst_n, start, busy, mode;
	logic [7:0]         electrode_slot;
	logic signed [23:0] pos_x, pos_z;
	logic [8:0]         current_a, current_b, potential_m, potential_n;
	logic               cfg_valid, cfg_ready;
	logic [1:0]         cfg_index;
	logic [23:0]        cfg_data;
	logic               done;
	logic signed [47:0] factor;
	logic [1:0]         status;
	longint             cycles;

	geom_factor_tracker book;

	four_electrode_geometric_factor DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .mode(mode),
		.electrode_slot(electrode_slot), .pos_x(pos_x), .pos_z(pos_z),
		.current_a(current_a), .current_b(current_b),
		.potential_m(potential_m), .potential_n(potential_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .done(done), .factor(factor), .status(status)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n && done)
			book.compare_result(factor, status);

	task automatic send_txn(electrode_txn_t t);
		@(negedge clk);
		start = 1;
		mode = t.mode;
		electrode_slot = t.slot;
		pos_x = t.px;
		pos_z = t.pz;
		current_a = t.ia;
		current_b = t.ib;
		potential_m = t.im;
		potential_n = t.in_n;
		do @(posedge clk); while (busy);
		book.log_transaction(t);
	endtask

	task automatic sender_gap();
		int n, r;
		r = $urandom_range(0, 99);
		n = r < 55 ? 0 : r < 92 ? $urandom_range(1, 3) : $urandom_range(10, 60);
		if (n > 0) begin
			@(negedge clk);
			start = 0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	task automatic write_cfg(cfg_idx_t idx, logic [23:0] val);
		@(negedge clk);
		start = 0;
		cfg_valid = 1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		book.write_bound(idx, val);
		@(negedge clk);
		cfg_valid = 0;
	endtask

	task automatic set_box(int xl, int xh, int zl, int zh);
		@(negedge clk);
		start = 0;
		while (book.pending_factors.size() != 0) @(negedge clk);
		write_cfg(CFG_X_LOW, xl[23:0]);
		write_cfg(CFG_X_HIGH, xh[23:0]);
		write_cfg(CFG_Z_LOW, zl[23:0]);
		write_cfg(CFG_Z_HIGH, zh[23:0]);
	endtask

	function automatic electrode_txn_t load_txn(int s, int x, int z);
		electrode_txn_t t;
		t = '{MODE_LOAD, s[7:0], x[23:0], z[23:0], 9'($urandom), 9'($urandom),
			9'($urandom), 9'($urandom)};
		return t;
	endfunction

	function automatic electrode_txn_t calc_txn(int a, int b, int m, int n);
		electrode_txn_t t;
		t = '{MODE_COMPUTE, 8'($urandom), 24'($urandom), 24'($urandom),
			a[8:0], b[8:0], m[8:0], n[8:0]};
		return t;
	endfunction

	function automatic int pick_index();
		int r, k;
		r = $urandom_range(0, 99);
		if (r < 8)
			return 0;
		if (r < 13)
			return $urandom_range(257, 511);
		k = $urandom_range(0, NumSlots - 1);
		for (int i = 0; i < NumSlots; i++)
			if (book.loaded[(k + i) % NumSlots])
				return (k + i) % NumSlots + 1;
		return 0;
	endfunction

	function automatic int pick_coord(int lo, int hi);
		int r, mn, mx;
		mn = lo < hi ? lo : hi;
		mx = lo < hi ? hi : lo;
		r = $urandom_range(0, 99);
		if (r < 20)
			return int'($urandom) <<< 8 >>> 8;
		if (r < 35)
			return $urandom_range(0, 1) ? mn - $urandom_range(0, 2) : mx + $urandom_range(0, 2);
		if (r < 60)
			return $urandom_range(0, 4000) - 2000;
		return mn + int'($urandom_range(0, mx - mn));
	endfunction

	task automatic random_phase(int count);
		electrode_txn_t t;
		int s, src;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) < 35) begin
				s = $urandom_range(0, NumSlots - 1);
				t = load_txn(s, pick_coord(book.bounds[CFG_X_LOW], book.bounds[CFG_X_HIGH]),
					pick_coord(book.bounds[CFG_Z_LOW], book.bounds[CFG_Z_HIGH]));
				if ($urandom_range(0, 9) == 0) begin
					src = pick_index();
					if (src >= 1 && src <= NumSlots) begin
						t.px = book.tab_x[src-1];
						t.pz = book.tab_z[src-1];
					end
				end
			end else
				t = calc_txn(pick_index(), pick_index(), pick_index(), pick_index());
			send_txn(t);
			sender_gap();
		end
	endtask

	initial begin
		book = new();
		cycles = 0;
		arst_n = 0;
		start = 0;
		mode = MODE_LOAD;
		electrode_slot = '0;
		pos_x = '0;
		pos_z = '0;
		current_a = '0;
		current_b = '0;
		potential_m = '0;
		potential_n = '0;
		cfg_valid = 0;
		cfg_index = CFG_X_LOW;
		cfg_data = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		send_txn(load_txn(0, 0, 0));
		send_txn(load_txn(1, 8388607, 0));
		send_txn(load_txn(2, 0, 8388606));
		send_txn(load_txn(3, -8388608, -8388608));
		send_txn(load_txn(255, 256, 256));
		send_txn(load_txn(4, 0, 0));
		send_txn(load_txn(5, 512, -768));
		send_txn(load_txn(6, 8388607, 8388607));
		send_txn(calc_txn(0, 0, 0, 0));
		send_txn(calc_txn(1, 0, 2, 0));
		send_txn(calc_txn(1, 0, 2, 3));
		send_txn(calc_txn(1, 0, 3, 2));
		send_txn(calc_txn(1, 0, 5, 0));
		send_txn(calc_txn(1, 6, 256, 2));
		send_txn(calc_txn(300, 4, 511, 7));
		send_txn(calc_txn(4, 7, 1, 6));
		send_txn(calc_txn(1, 2, 1, 2));
		send_txn(calc_txn(4, 1, 256, 6));
		sender_gap();

		set_box(-8388608, 8388607, -8388608, 8388607);
		random_phase(300);
		set_box(8388607, -8388608, 8388607, -8388608);
		random_phase(250);
		set_box(-20000, 30000, 50000, -50000);
		send_txn(load_txn(10, 30001, 0));
		send_txn(load_txn(10, 0, -50001));
		send_txn(load_txn(10, -20000, 50000));
		random_phase(250);
		set_box(0, 0, -8388608, -8388608);
		random_phase(60);
		set_box(-8388608, 8388607, -8388608, 8388607);
		random_phase(270);

		@(negedge clk);
		start = 0;
		while (book.pending_factors.size() != 0) @(posedge clk);
		repeat (LatencyCycles + 20) @(posedge clk);
		if (book.fails == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule

/* filelist.f */
rtl/core/fegf_pkg.sv
rtl/core/fegf_isqrt.sv
rtl/core/fegf_div.sv
rtl/core/four_electrode_geometric_factor.sv
rtl/core/fegf_checker.sv
tb/sv/tb_four_electrode_geometric_factor.sv
